/* design/wbps_pkg.sv */
package wbps_pkg;

  // Default sizes, handed to the top level parameters
  localparam int PATTERN_MAX_DEF = 32;
  localparam int OFFSET_BITS_DEF = 32;

  // Pattern storage held by the register file
  localparam int PAT_STORED = 32;
  localparam int PAT_WORDS  = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd5;

  localparam int LEN_REG_W = 6;
  localparam int OFFSET_OUT_W = 32;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_last;
  } entry_t;

endpackage

/* design/wbps_if.sv */
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_last;

  modport source (output valid, output data_byte, output region_last, input ready);
  modport sink (input valid, input data_byte, input region_last, output ready);
endinterface

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink (input valid, input found, input match_offset, output ready);
endinterface

/* design/wbps_cfg.sv */
module wbps_cfg #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  localparam int NW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [7:0]                       pat_byte [PATTERN_MAX],
  output logic [PATTERN_MAX-1:0]           pat_wild,
  output logic [NW-1:0]                    used_len
);

  logic [wbps_pkg::CFG_DATA_W-1:0] word_r [wbps_pkg::PAT_WORDS];
  logic [wbps_pkg::PAT_STORED-1:0] wild_r;
  logic [wbps_pkg::LEN_REG_W-1:0]  len_r;
  logic [6:0]                      len_ext;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < wbps_pkg::PAT_WORDS; w++) word_r[w] <= '0;
      wild_r <= '0;
      len_r  <= wbps_pkg::LEN_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_PATTERN_0: word_r[0] <= cfg_data;
        wbps_pkg::REG_PATTERN_1: word_r[1] <= cfg_data;
        wbps_pkg::REG_PATTERN_2: word_r[2] <= cfg_data;
        wbps_pkg::REG_PATTERN_3: word_r[3] <= cfg_data;
        wbps_pkg::REG_WILDCARD:  wild_r <= cfg_data[wbps_pkg::PAT_STORED-1:0];
        wbps_pkg::REG_LENGTH:    len_r <= cfg_data[wbps_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack pattern bytes; bytes past the stored ones read as literal zero
  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
    if (g < wbps_pkg::PAT_STORED) begin : g_stored
      localparam int WI = g / 8;
      localparam int BI = g % 8;
      assign pat_byte[g] = word_r[WI][8*BI +: 8];
      assign pat_wild[g] = wild_r[g];
    end else begin : g_blank
      assign pat_byte[g] = 8'h00;
      assign pat_wild[g] = 1'b0;
    end
  end

  // Clamp the length to 1..PATTERN_MAX
  assign len_ext = {1'b0, len_r};

  always_comb begin
    if (len_ext == 7'd0) begin
      used_len = NW'(1);
    end else if (len_ext > 7'(PATTERN_MAX)) begin
      used_len = NW'(PATTERN_MAX);
    end else begin
      used_len = NW'(len_ext);
    end
  end

endmodule

/* design/wbps_front.sv */
module wbps_front (
  input  logic              clk,
  input  logic              rst_n,
  wbps_in_if.sink           in_ch,
  output logic              q_valid,
  output wbps_pkg::entry_t  q_head,
  input  logic              q_pop
);

  localparam int QPW = $clog2(wbps_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(wbps_pkg::QUEUE_DEPTH + 1);

  wbps_pkg::entry_t mem [wbps_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push;
  logic             pop;
  wbps_pkg::entry_t entry;

  // Accept a word whenever the queue has room
  assign in_ch.ready = (cnt_r != QCW'(wbps_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && q_valid;

  // Copy the word into a queue entry
  assign entry.data_byte   = in_ch.data_byte;
  assign entry.region_last = in_ch.region_last;

  assign q_valid = (cnt_r != '0);
  assign q_head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* design/wbps_back.sv */
module wbps_back #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF,
  localparam int NW = $clog2(PATTERN_MAX + 1),
  localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  wbps_pkg::entry_t        q_head,
  output logic                    q_pop,
  input  logic [7:0]              pat_byte [PATTERN_MAX],
  input  logic [PATTERN_MAX-1:0]  pat_wild,
  input  logic [NW-1:0]           used_len,
  wbps_out_if.source              out_ch
);

  // Window stage: holds the window including the word under compare
  logic [7:0]             win_r   [PATTERN_MAX];
  logic [7:0]             win_nxt [PATTERN_MAX];
  logic [NW-1:0]          fill_r, fill_nxt, fill_base;
  logic [OFFSET_BITS-1:0] count_r, count_nxt, count_base;
  logic                   last_r;
  logic                   s1_valid_r, s1_valid_nxt;

  // Compare and result
  logic [PATTERN_MAX-1:0] hit;
  logic                   matched_r, matched_nxt;
  logic                   adv;
  logic                   match;
  logic                   produce;
  logic [OFFSET_BITS-1:0] off;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_found_r;
  logic [wbps_pkg::OFFSET_OUT_W-1:0]  out_offset_r;

  // Advance the compare stage when the output slot is free or draining
  assign adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign q_pop = q_valid && (!s1_valid_r || adv);

  // Shift the next word in; restart after a region's last word
  always_comb begin
    fill_base  = last_r ? '0 : fill_r;
    count_base = last_r ? '0 : count_r;
    win_nxt[0] = q_head.data_byte;
    for (int p = 1; p < PATTERN_MAX; p++) win_nxt[p] = win_r[p-1];
    fill_nxt   = (fill_base == NW'(PATTERN_MAX)) ? fill_base : fill_base + NW'(1);
    count_nxt  = count_base + OFFSET_BITS'(1);
    s1_valid_nxt = q_pop || (s1_valid_r && !adv);
  end

  // Masked compare of the newest used_len window bytes
  always_comb begin
    logic [NW:0]   kk;
    logic [NW:0]   diff;
    logic [PW-1:0] idx;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      kk     = (NW+1)'(k);
      diff   = {1'b0, used_len} - kk - (NW+1)'(1);
      idx    = diff[PW-1:0];
      hit[k] = pat_wild[k] || (kk >= {1'b0, used_len}) || (win_r[idx] == pat_byte[k]);
    end
  end

  always_comb begin
    match       = !matched_r && (fill_r >= used_len) && (&hit);
    produce     = match || (last_r && !matched_r);
    off         = count_r - OFFSET_BITS'(used_len);
    matched_nxt = last_r ? 1'b0 : (matched_r || match);
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (adv && produce) out_valid_nxt = 1'b1;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      win_r <= win_nxt;
    end
    if (adv && produce) begin
      out_found_r  <= match;
      out_offset_r <= match ? wbps_pkg::OFFSET_OUT_W'(off) : '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      count_r     <= '0;
      last_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      matched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        fill_r  <= fill_nxt;
        count_r <= count_nxt;
        last_r  <= q_head.region_last;
      end
      if (adv) matched_r <= matched_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.match_offset = out_offset_r;

endmodule

/* design/wildcard_byte_pattern_scan.sv */
// Wildcard byte pattern scanner.
// in_ch carries one region byte per word with a last-of-region mark; out_ch
// carries at most one result per region: found with the offset of the first
// byte of the first match, or not found (offset 0) when the region ends
// without one. A match must lie wholly inside the region.
// Program the pattern words, wildcard mask and length through the cfg_ port
// while no bytes are in flight; each write takes effect at once.
// Throughput: one byte per cycle while out_ch takes results, set by the masked
// compare of the whole window against the pattern. A result reaches out_ch
// through the front queue, then the window/compare stage, into the output
// register.
// When out_ch stalls, the result waits in the output register, the compare
// stage holds its byte and the four-entry queue keeps taking bytes until full,
// at which point in_ch.ready drops.
// Reset clears the queue, window fill, byte count and match flag, and loads
// the register defaults: zero pattern, no wildcards, length one. No clearing
// pass is needed; the block takes bytes from the first cycle after reset.
module wildcard_byte_pattern_scan #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wbps_in_if.sink                          in_ch,
  wbps_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NW = $clog2(PATTERN_MAX + 1);

  logic [7:0]             pat_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] pat_wild;
  logic [NW-1:0]          used_len;
  logic                   q_valid;
  logic                   q_pop;
  wbps_pkg::entry_t       q_head;

  wbps_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_byte  (pat_byte),
    .pat_wild  (pat_wild),
    .used_len  (used_len)
  );

  wbps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  wbps_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .pat_byte (pat_byte),
    .pat_wild (pat_wild),
    .used_len (used_len),
    .out_ch   (out_ch)
  );

endmodule
